// File: rtl/lcdnw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lcdnw_pkg;

  localparam int HOLD_W    = 24;
  localparam int SETUP_W   = 16;
  localparam int PULSE_W   = 20;
  localparam int CFG_W     = 20;
  localparam int CFG_IDX_W = 2;
  localparam int STEP_W    = 6;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_GOTO  = 2'd1;
  localparam logic [1:0] CMD_INIT  = 2'd2;
  localparam logic [1:0] CMD_NONE  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_SETUP     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CMD_PULSE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DAT_PULSE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POWERUP   = 2'd3;

  localparam logic [SETUP_W-1:0] SETUP_RST     = 16'd20;
  localparam logic [PULSE_W-1:0] CMD_PULSE_RST = 20'd5000;
  localparam logic [PULSE_W-1:0] DAT_PULSE_RST = 20'd200;
  localparam logic [PULSE_W-1:0] POWERUP_RST   = 20'd100000;

  localparam logic [7:0] ROW0_BASE = 8'h80;
  localparam logic [7:0] ROW1_BASE = 8'hC0;

  typedef struct packed {
    logic       init;
    logic [7:0] value;
    logic       rs;
  } job_t;

  typedef struct packed {
    logic [SETUP_W-1:0] setup_us;
    logic [PULSE_W-1:0] command_pulse_us;
    logic [PULSE_W-1:0] data_pulse_us;
    logic [PULSE_W-1:0] powerup_us;
  } cfg_t;

  function automatic logic [7:0] init_byte(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0: b = 8'h03;
      3'd1: b = 8'h03;
      3'd2: b = 8'h03;
      3'd3: b = 8'h02;
      3'd4: b = 8'h28;
      3'd5: b = 8'h0C;
      3'd6: b = 8'h01;
      default: b = 8'h06;
    endcase
    return b;
  endfunction

  function automatic logic [HOLD_W-1:0] init_wait(input logic [2:0] idx);
    logic [HOLD_W-1:0] w;
    unique case (idx)
      3'd0: w = 24'd5000;
      3'd6: w = 24'd2000;
      default: w = 24'd1000;
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// File: rtl/lcdnw_front.sv
`timescale 1ns / 1ps
`default_nettype none
module lcdnw_front (
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [15:0]      s_tdata,
  input  wire logic [1:0]       s_tuser,
  output logic                  push,
  output lcdnw_pkg::job_t       push_job,
  input  wire logic             push_ready
);

  logic [7:0] value;
  logic       rs;
  logic [5:0] column;
  logic       row;

  assign value  = s_tdata[7:0];
  assign rs     = s_tdata[8];
  assign column = s_tdata[14:9];
  assign row    = s_tdata[15];

  assign s_tready = push_ready;

  always_comb begin
    push_job = '0;
    push     = 1'b0;
    unique case (s_tuser)
      lcdnw_pkg::CMD_WRITE: begin
        push_job.value = value;
        push_job.rs    = rs;
        push           = s_tvalid;
      end
      lcdnw_pkg::CMD_GOTO: begin
        push_job.value = (row ? lcdnw_pkg::ROW1_BASE : lcdnw_pkg::ROW0_BASE) | {2'b00, column};
        push           = s_tvalid;
      end
      lcdnw_pkg::CMD_INIT: begin
        push_job.init  = 1'b1;
        push           = s_tvalid;
      end
      default: begin
        // unused code: beat taken and dropped
        push = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/lcdnw_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module lcdnw_queue #(
  parameter int DEPTH = lcdnw_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire lcdnw_pkg::job_t push_job,
  output logic                 push_ready,
  output logic                 head_valid,
  output lcdnw_pkg::job_t      head_job,
  input  wire logic            pop
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  lcdnw_pkg::job_t   entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != FULL_CNT);
  assign head_valid = (count != '0);
  assign head_job   = entries[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/lcdnw_back.sv
`timescale 1ns / 1ps
`default_nettype none
module lcdnw_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire lcdnw_pkg::cfg_t cfg,
  input  wire logic            head_valid,
  input  wire lcdnw_pkg::job_t head_job,
  output logic                 pop,
  output logic                 m_tvalid,
  input  wire logic            m_tready,
  output logic [31:0]          m_tdata,
  output logic                 m_tlast
);

  localparam int HW = lcdnw_pkg::HOLD_W;

  logic [lcdnw_pkg::STEP_W-1:0] step;
  logic [3:0]                   prev_nib;
  logic                         advance;
  logic                         emit;
  logic [2:0]                   byte_idx;
  logic                         low_half;
  logic [1:0]                   seg;
  logic [7:0]                   cur_byte;
  logic [3:0]                   nib;
  logic                         rs_lvl;
  logic [HW-1:0]                setup_ext;
  logic [HW-1:0]                extra;
  logic [HW-1:0]                hold;
  logic                         final_seg;
  logic [3:0]                   data_lvl;
  logic                         en_lvl;

  // step = {byte index, nibble half, segment}
  assign byte_idx = step[5:3];
  assign low_half = step[2];
  assign seg      = step[1:0];

  assign advance = !m_tvalid || m_tready;
  assign emit    = advance && head_valid;

  assign cur_byte  = head_job.init ? lcdnw_pkg::init_byte(byte_idx) : head_job.value;
  assign nib       = low_half ? cur_byte[3:0] : cur_byte[7:4];
  assign rs_lvl    = head_job.init ? 1'b0 : head_job.rs;
  assign setup_ext = HW'(cfg.setup_us);
  assign final_seg = (seg == 2'd3) && low_half && (!head_job.init || byte_idx == 3'd7);
  assign pop       = emit && final_seg;

  always_comb begin
    extra    = '0;
    data_lvl = nib;
    en_lvl   = 1'b0;
    hold     = setup_ext;
    unique case (seg)
      2'd0: begin
        data_lvl = prev_nib;
        if (head_job.init && step == '0) begin
          extra = HW'(cfg.powerup_us);
        end
        hold = setup_ext + extra;
      end
      2'd1: begin
        hold = setup_ext;
      end
      2'd2: begin
        en_lvl = 1'b1;
        hold   = rs_lvl ? HW'(cfg.data_pulse_us) : HW'(cfg.command_pulse_us);
      end
      default: begin
        if (head_job.init && low_half) begin
          extra = lcdnw_pkg::init_wait(byte_idx);
        end
        hold = setup_ext + extra;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      step     <= '0;
      prev_nib <= '0;
    end else if (advance) begin
      m_tvalid <= head_valid;
      if (head_valid) begin
        step <= final_seg ? '0 : step + 1'b1;
        if (seg == 2'd3) begin
          prev_nib <= nib;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= {2'b00, hold, en_lvl, data_lvl, rs_lvl};
      m_tlast <= final_seg;
    end
  end

endmodule
`default_nettype wire

// File: rtl/char_lcd_nibble_write_sequencer_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Character LCD sequencer for a 4-bit HD44780-style bus. Each input beat is a
// byte write, a cursor move or the init sequence (s_tuser); each output beat is
// one timed pin state for the board-level timer to hold for hold_us. A byte
// write or cursor move gives 8 output beats, init gives 64, one per cycle while
// m_tready is high; the back-end step counter sets that pace. A small job queue
// lets new requests be taken while earlier ones are still being sent. Unused
// command code 3 is accepted and dropped. Configuration writes take effect at
// once and should be made only while no request is in progress.
module char_lcd_nibble_write_sequencer_top #(
  parameter int QUEUE_DEPTH = lcdnw_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [15:0]                    s_tdata,   // value[7:0], rs, column[5:0], row
  input  wire logic [1:0]                     s_tuser,   // cmd
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic [31:0]                         m_tdata,   // rs_pin, data_pins[3:0], en_pin,
                                                         // hold_us[23:0], zero pad
  output logic                                m_tlast,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [lcdnw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [lcdnw_pkg::CFG_W-1:0]     cfg_data
);

  lcdnw_pkg::cfg_t cfg;
  logic            push;
  lcdnw_pkg::job_t push_job;
  logic            push_ready;
  logic            head_valid;
  lcdnw_pkg::job_t head_job;
  logic            pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.setup_us         <= lcdnw_pkg::SETUP_RST;
      cfg.command_pulse_us <= lcdnw_pkg::CMD_PULSE_RST;
      cfg.data_pulse_us    <= lcdnw_pkg::DAT_PULSE_RST;
      cfg.powerup_us       <= lcdnw_pkg::POWERUP_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        lcdnw_pkg::REG_SETUP:     cfg.setup_us         <= cfg_data[lcdnw_pkg::SETUP_W-1:0];
        lcdnw_pkg::REG_CMD_PULSE: cfg.command_pulse_us <= cfg_data;
        lcdnw_pkg::REG_DAT_PULSE: cfg.data_pulse_us    <= cfg_data;
        default:                  cfg.powerup_us       <= cfg_data;
      endcase
    end
  end

  lcdnw_front u_front (
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .push       (push),
    .push_job   (push_job),
    .push_ready (push_ready)
  );

  lcdnw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .push_ready (push_ready),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop)
  );

  lcdnw_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

endmodule
`default_nettype wire
